[sv/idxh_pkg.sv]
// shared types and constants of the interleaved djb2 xor hash
package idxh_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HASH_SHIFT = 5;
  localparam int unsigned DIV_STEPS  = HASH_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [HASH_W-1:0] HASH_SEED     = 32'd5381;
  localparam logic [HASH_W-1:0] HASH_MIX      = 32'd1566083941;
  localparam logic [HASH_W-1:0] BUCKET_RESET  = 32'd1;

  typedef struct packed {
    logic lane_en;
    logic mul_en;
    logic hash_en;
    logic div_en;
    logic out_load;
  } idxh_cmd_t;

endpackage

[sv/idxh_if.sv]
// valid/ready channels for message bytes and hash results
interface idxh_in_if;
  logic                               valid;
  logic                               ready;
  logic [idxh_pkg::BYTE_W-1:0]        data_byte;
  logic                               no_byte;
  logic                               last;

  modport source (output valid, data_byte, no_byte, last, input ready);
  modport sink (input valid, data_byte, no_byte, last, output ready);
endinterface

interface idxh_out_if;
  logic                               valid;
  logic                               ready;
  logic [idxh_pkg::HASH_W-1:0]        hash_value;
  logic [idxh_pkg::HASH_W-1:0]        bucket;

  modport source (output valid, hash_value, bucket, input ready);
  modport sink (input valid, hash_value, bucket, output ready);
endinterface

[sv/idxh_dp.sv]
// datapath: hash lanes, combining multiply, bucket remainder and result register
module idxh_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idxh_pkg::idxh_cmd_t           cmd,
  input  logic [idxh_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          no_byte,
  input  logic                          cfg_we,
  input  logic [idxh_pkg::HASH_W-1:0]   cfg_wdata,
  output logic [idxh_pkg::HASH_W-1:0]   hash_value,
  output logic [idxh_pkg::HASH_W-1:0]   bucket
);
  import idxh_pkg::*;

  logic [HASH_W-1:0] lane_one_r, lane_one_nxt;
  logic [HASH_W-1:0] lane_two_r, lane_two_nxt;
  logic              odd_r, odd_nxt;
  logic              stopped_r, stopped_nxt;
  logic [HASH_W-1:0] bucket_count_r;
  logic [HASH_W-1:0] prod_r;
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] dvd_r;
  logic [HASH_W-1:0] rem_r, rem_nxt;
  logic [HASH_W-1:0] out_hash_r;
  logic [HASH_W-1:0] out_bucket_r;

  logic [HASH_W-1:0] ext;
  logic [HASH_W-1:0] lane_sel;
  logic [HASH_W-1:0] lane_upd;
  logic [HASH_W:0]   rem_shift;
  logic [HASH_W:0]   divisor;
  logic              take;

  assign ext      = {{(HASH_W-BYTE_W){data_byte[BYTE_W-1]}}, data_byte};
  assign lane_sel = odd_r ? lane_two_r : lane_one_r;
  assign lane_upd = ((lane_sel << HASH_SHIFT) + lane_sel) ^ ext;

  always_comb begin
    lane_one_nxt = lane_one_r;
    lane_two_nxt = lane_two_r;
    odd_nxt      = odd_r;
    stopped_nxt  = stopped_r;
    if (cmd.hash_en) begin
      lane_one_nxt = HASH_SEED;
      lane_two_nxt = HASH_SEED;
      odd_nxt      = 1'b0;
      stopped_nxt  = 1'b0;
    end else if (cmd.lane_en && !no_byte && !stopped_r) begin
      if (data_byte == '0) begin
        stopped_nxt = 1'b1;
      end else begin
        if (odd_r) lane_two_nxt = lane_upd;
        else lane_one_nxt = lane_upd;
        odd_nxt = !odd_r;
      end
    end
  end

  // restoring remainder, one quotient bit per step; zero divisor leaves the dividend
  assign rem_shift = {rem_r, dvd_r[HASH_W-1]};
  assign divisor   = {1'b0, bucket_count_r};
  assign take      = rem_shift >= divisor;
  assign rem_nxt   = take ? HASH_W'(rem_shift - divisor) : rem_shift[HASH_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_one_r     <= HASH_SEED;
      lane_two_r     <= HASH_SEED;
      odd_r          <= 1'b0;
      stopped_r      <= 1'b0;
      bucket_count_r <= BUCKET_RESET;
    end else begin
      lane_one_r <= lane_one_nxt;
      lane_two_r <= lane_two_nxt;
      odd_r      <= odd_nxt;
      stopped_r  <= stopped_nxt;
      if (cfg_we) bucket_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= HASH_W'(lane_two_r * HASH_MIX);
    if (cmd.hash_en) begin
      hash_r <= lane_one_r + prod_r;
      dvd_r  <= lane_one_r + prod_r;
      rem_r  <= '0;
    end else if (cmd.div_en) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      out_hash_r   <= hash_r;
      out_bucket_r <= rem_r;
    end
  end

  assign hash_value = out_hash_r;
  assign bucket     = out_bucket_r;

endmodule

[sv/idxh_ctrl.sv]
// controller: byte intake, end-of-message sequence and result handshake
module idxh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output idxh_pkg::idxh_cmd_t  cmd
);
  import idxh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_HASH,
    S_DIV,
    S_DONE
  } state_t;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  state_t               state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic                 in_xfer;
  logic                 out_free;

  assign in_ready  = state_r == S_IDLE;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.lane_en  = in_xfer;
    cmd.mul_en   = state_r == S_MUL;
    cmd.hash_en  = state_r == S_HASH;
    cmd.div_en   = state_r == S_DIV;
    cmd.out_load = (state_r == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && in_last) state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_HASH;
        end
        S_HASH: begin
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (cnt_r == '0))
    else $error("step counter moved outside divide");

  a_last_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> (state_r == S_MUL))
    else $error("last transfer did not start the result sequence");

  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_DONE))
    else $error("divide did not end after its last step");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not offered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.out_load)
    else $error("pending result overwritten");

endmodule

[sv/interleaved_djb2_xor_hash.sv]
// top level of the interleaved djb2 xor hash with bucket reduction
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        data_byte[7:0], no_byte, last
//   out_ch    out  valid/ready        hash_value[31:0], bucket[31:0]
//   cfg       in   cfg_we             cfg_wdata[31:0] -> bucket_count
//
// a byte without last leaves the intake ready; after a last transfer no byte is
// taken until these steps end: multiply, combine, 32 remainder steps, result load.
// the remainder unit's one bit per cycle sets the end-of-message time.
// a held result stalls the load step, and no bytes are taken while it waits.
// rst_n is synchronous: lanes at 5381, bucket_count at 1, no result pending.
module interleaved_djb2_xor_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  idxh_in_if.sink                      in_ch,
  idxh_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [idxh_pkg::HASH_W-1:0]  cfg_wdata
);
  import idxh_pkg::*;

  idxh_cmd_t cmd;

  idxh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  idxh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .data_byte  (in_ch.data_byte),
    .no_byte    (in_ch.no_byte),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .hash_value (out_ch.hash_value),
    .bucket     (out_ch.bucket)
  );

endmodule
